/* hdl/mcl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcl_pkg - shared types and constants of the mip chain layout block
// Field widths, register indexes, texture kinds and the pipeline metadata.
// ----------------------------------------------------------------------------
package mcl_pkg;

    // Defaults of the top-level parameters
    localparam int unsigned MAX_DIM_DEF    = 16384;
    localparam int unsigned MAX_LEVELS_DEF = 15;

    // Field widths
    localparam int unsigned DIM_W   = 15;
    localparam int unsigned LVL_W   = 4;
    localparam int unsigned BPP_W   = 8;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned BYTE_W  = 48;
    localparam int unsigned CIDX_W  = 2;
    localparam int unsigned CDAT_W  = 8;

    // Product widths along the pipeline
    localparam int unsigned P1_W = 2 * DIM_W;          // width * height
    localparam int unsigned P2_W = P1_W + DIM_W;       // times depth or faces
    localparam int unsigned P3_W = P2_W + BPP_W;       // times bits per texel

    // Faces of a cube map
    localparam logic [DIM_W-1:0] CUBE_FACES = DIM_W'(6);

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_KIND  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_BPP   = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_COUNT = 2'd2;

    typedef enum logic [KIND_W-1:0] {
        KIND_1D   = 2'd0,
        KIND_2D   = 2'd1,
        KIND_3D   = 2'd2,
        KIND_CUBE = 2'd3
    } t_kind;

    // Level bookkeeping that travels with each record
    typedef struct packed {
        logic [LVL_W-1:0] lvl;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        logic [DIM_W-1:0] d;
        logic             last;
    } t_meta;

    // Map zero to one and saturate at the configured maximum
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d,
                                                   input int unsigned mx);
        logic [DIM_W-1:0] r;
        r = d;
        if (d == '0) begin
            r = DIM_W'(1);
        end else if (int'(d) > int'(mx)) begin
            r = DIM_W'(mx);
        end
        return r;
    endfunction

    // Halve with a floor of one
    function automatic logic [DIM_W-1:0] halve(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        r = d >> 1;
        if (r == '0) begin
            r = DIM_W'(1);
        end
        return r;
    endfunction

endpackage

/* hdl/mcl_ifs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcl_ifs - channel interfaces of the mip chain layout block
// Base dimension input, level record output and register write channels.
// ----------------------------------------------------------------------------
interface mcl_in_if import mcl_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [DIM_W-1:0] base_width;
    logic [DIM_W-1:0] base_height;
    logic [DIM_W-1:0] base_depth;

    modport source (output valid, base_width, base_height, base_depth, input ready);
    modport sink   (input valid, base_width, base_height, base_depth, output ready);
endinterface

interface mcl_out_if import mcl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [LVL_W-1:0]  level_index;
    logic [BYTE_W-1:0] byte_offset;
    logic [BYTE_W-1:0] byte_size;
    logic [DIM_W-1:0]  level_width;
    logic [DIM_W-1:0]  level_height;
    logic [DIM_W-1:0]  level_depth;
    logic              chain_last;
    logic [BYTE_W-1:0] chain_total;

    modport source (output valid, level_index, byte_offset, byte_size, level_width,
                    level_height, level_depth, chain_last, chain_total, input ready);
    modport sink   (input valid, level_index, byte_offset, byte_size, level_width,
                    level_height, level_depth, chain_last, chain_total, output ready);
endinterface

interface mcl_cfg_if import mcl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CIDX_W-1:0] index;
    logic [CDAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/mip_chain_layout.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mip_chain_layout - mipmap chain offset and size calculator
// Expands one set of base dimensions into one record per mip level.
// ----------------------------------------------------------------------------
// Usage:
//   i_cfg  : register writes (texture kind, bits per texel, level count),
//            always ready; write only while the block is idle.
//   i_in   : one beat carries the base width, height and depth of a texture.
//   o_out  : one beat per mip level, level 0 first; the final beat sets
//            chain_last and carries the chain total.
// Pipeline: the first record of an item passes the sequencer load at the
//   accepting edge, then three multiply stages and the offset accumulator.
// Throughput: one record per cycle while o_out.ready is high, and level_count
//   records per item (1 to 15). The level sequencer issues one level per cycle
//   unless stalled and takes the next input beat as it issues the final level.
// Reset: registers return to 2D, 32 bits per texel, one level; the pipeline
//   and sequencer are emptied.
// Stall: when o_out.ready is low the output register holds its beat, empty
//   stages ahead of it keep filling, and the sequencer pauses once the
//   pipeline is full; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module mip_chain_layout
    import mcl_pkg::*;
#(
    parameter int unsigned MAX_DIM    = MAX_DIM_DEF,
    parameter int unsigned MAX_LEVELS = MAX_LEVELS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mcl_cfg_if.sink     i_cfg,
    mcl_in_if.sink      i_in,
    mcl_out_if.source   o_out
);

    // Configuration registers
    t_kind             r_kind;
    logic [BPP_W-1:0]  r_bpp;
    logic [LVL_W-1:0]  r_count;

    // Level sequencer
    logic              r_busy;
    logic [LVL_W-1:0]  r_lvl;
    logic [LVL_W-1:0]  r_lvl_end;
    logic [DIM_W-1:0]  r_w;
    logic [DIM_W-1:0]  r_h;
    logic [DIM_W-1:0]  r_d;
    logic              n_busy;
    logic [LVL_W-1:0]  n_lvl;
    logic [LVL_W-1:0]  n_lvl_end;
    logic [DIM_W-1:0]  n_w;
    logic [DIM_W-1:0]  n_h;
    logic [DIM_W-1:0]  n_d;

    // Pipeline stages
    logic              r_v1, r_v2, r_v3, r_v4;
    t_meta             r_m1, r_m2, r_m3, r_m4;
    logic [P1_W-1:0]   r_p1;
    logic [P2_W-1:0]   r_p2;
    logic [P3_W-1:0]   r_p3;
    logic [BYTE_W-1:0] r_acc;
    logic [BYTE_W-1:0] r_off;
    logic [BYTE_W-1:0] r_size;
    logic [BYTE_W-1:0] r_total;

    logic              ld1, ld2, ld3, ld4;
    logic              issue;
    logic              seq_last;
    logic              in_fire;
    logic [LVL_W-1:0]  cnt_eff;
    logic [DIM_W-1:0]  factor;
    logic [BYTE_W-1:0] size3;
    logic [BYTE_W-1:0] off3;
    logic [BYTE_W-1:0] sum3;

    // Register writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind  <= KIND_2D;
            r_bpp   <= BPP_W'(32);
            r_count <= LVL_W'(1);
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_KIND:  r_kind  <= t_kind'(i_cfg.data[KIND_W-1:0]);
                CFG_BPP:   r_bpp   <= i_cfg.data[BPP_W-1:0];
                CFG_COUNT: r_count <= i_cfg.data[LVL_W-1:0];
                default:   ;
            endcase
        end
    end

    // Stage load enables: a stage loads when empty or when its beat moves on
    assign ld4 = !r_v4 || o_out.ready;
    assign ld3 = !r_v3 || ld4;
    assign ld2 = !r_v2 || ld3;
    assign ld1 = !r_v1 || ld2;

    assign issue      = r_busy && ld1;
    assign seq_last   = (r_lvl == r_lvl_end);
    assign i_in.ready = !r_busy || (issue && seq_last);
    assign in_fire    = i_in.valid && i_in.ready;

    // Effective level count: zero means one, saturate at the maximum
    always_comb begin
        cnt_eff = r_count;
        if (r_count == '0) begin
            cnt_eff = LVL_W'(1);
        end else if (int'(r_count) > int'(MAX_LEVELS)) begin
            cnt_eff = LVL_W'(MAX_LEVELS);
        end
    end

    // Sequencer next state: load a texture or step to the next level
    always_comb begin
        n_busy    = r_busy;
        n_lvl     = r_lvl;
        n_lvl_end = r_lvl_end;
        n_w       = r_w;
        n_h       = r_h;
        n_d       = r_d;
        if (in_fire) begin
            n_busy    = 1'b1;
            n_lvl     = '0;
            n_lvl_end = cnt_eff - LVL_W'(1);
            n_w       = clamp_dim(i_in.base_width, MAX_DIM);
            n_h       = (r_kind == KIND_1D) ? DIM_W'(1)
                                            : clamp_dim(i_in.base_height, MAX_DIM);
            n_d       = (r_kind == KIND_3D) ? clamp_dim(i_in.base_depth, MAX_DIM)
                                            : DIM_W'(1);
        end else if (issue) begin
            if (seq_last) begin
                n_busy = 1'b0;
            end else begin
                n_lvl = r_lvl + LVL_W'(1);
                n_w   = halve(r_w);
                n_h   = halve(r_h);
                n_d   = halve(r_d);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_lvl     <= n_lvl;
        r_lvl_end <= n_lvl_end;
        r_w       <= n_w;
        r_h       <= n_h;
        r_d       <= n_d;
    end

    // Face or depth factor of the second multiply
    always_comb begin
        case (r_kind)
            KIND_3D:   factor = r_m1.d;
            KIND_CUBE: factor = CUBE_FACES;
            default:   factor = DIM_W'(1);
        endcase
    end

    // Size and running offset of the record entering the output register
    assign size3 = r_p3[BYTE_W+2:3];
    assign off3  = (r_m3.lvl == '0) ? '0 : r_acc;
    assign sum3  = off3 + size3;

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (ld1) r_v1 <= r_busy;
            if (ld2) r_v2 <= r_v1;
            if (ld3) r_v3 <= r_v2;
            if (ld4) r_v4 <= r_v3;
        end
    end

    // Stage payloads: width*height, times factor, times bits per texel, offset
    always_ff @(posedge i_clk) begin
        if (ld1) begin
            r_m1.lvl  <= r_lvl;
            r_m1.w    <= r_w;
            r_m1.h    <= r_h;
            r_m1.d    <= r_d;
            r_m1.last <= seq_last;
            r_p1      <= P1_W'(r_w) * P1_W'(r_h);
        end
        if (ld2) begin
            r_m2 <= r_m1;
            r_p2 <= P2_W'(r_p1) * P2_W'(factor);
        end
        if (ld3) begin
            r_m3 <= r_m2;
            r_p3 <= P3_W'(r_p2) * P3_W'(r_bpp);
        end
        if (ld4 && r_v3) begin
            r_m4    <= r_m3;
            r_off   <= off3;
            r_size  <= size3;
            r_total <= r_m3.last ? sum3 : '0;
            r_acc   <= sum3;
        end
    end

    // Output beat
    assign o_out.valid        = r_v4;
    assign o_out.level_index  = r_m4.lvl;
    assign o_out.byte_offset  = r_off;
    assign o_out.byte_size    = r_size;
    assign o_out.level_width  = r_m4.w;
    assign o_out.level_height = r_m4.h;
    assign o_out.level_depth  = r_m4.d;
    assign o_out.chain_last   = r_m4.last;
    assign o_out.chain_total  = r_total;

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_busy)
        else $error("sequencer not busy after input beat");

    a_first_offset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && r_m4.lvl == '0) |-> (r_off == '0))
        else $error("level zero record with nonzero offset");

    a_total_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && r_m4.last) |-> (r_total == r_off + r_size))
        else $error("chain total does not match last offset plus size");

    a_total_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && !r_m4.last) |-> (r_total == '0))
        else $error("chain total set on a record that is not last");
`endif

endmodule
